/* rtl/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define TSPQ_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tspq assertion failed");

// next-cycle implication, clocked on clk, off while arst_n is low
`define TSPQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tspq assertion failed");

`endif

/* rtl/tspq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspq_pkg
// Types and constants of the timestamp priority queue.
// ----------------------------------------------------------------------------
package tspq_pkg;

	localparam int DEPTH   = 16;
	localparam int ID_BITS = 4;
	localparam int TIME_W  = 15;
	localparam int CMD_W   = 2;
	localparam int CNT_W   = $clog2(DEPTH + 1);

	localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0]  time_v;
		logic [ID_BITS-1:0] id;
	} slot_t;

	typedef struct packed {
		logic  push;
		logic  shift;
		slot_t key;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WORK = 2'b10
	} state_t;

endpackage

/* rtl/tspq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspq_if
// Request and response word channels of the timestamp priority queue.
// ----------------------------------------------------------------------------
interface tspq_req_if;
	logic                        valid;
	logic                        ready;
	logic [tspq_pkg::CMD_W-1:0]  cmd;
	logic [tspq_pkg::TIME_W-1:0] entry_time;
	logic [tspq_pkg::ID_BITS-1:0] entry_id;

	modport source (output valid, output cmd, output entry_time, output entry_id,
		input ready);
	modport sink (input valid, input cmd, input entry_time, input entry_id,
		output ready);
endinterface

interface tspq_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         head_valid;
	logic [tspq_pkg::TIME_W-1:0]  head_time;
	logic [tspq_pkg::ID_BITS-1:0] head_id;
	logic [tspq_pkg::CNT_W-1:0]   entry_count;
	logic                         overflow;

	modport source (output valid, output head_valid, output head_time, output head_id,
		output entry_count, output overflow, input ready);
	modport sink (input valid, input head_valid, input head_time, input head_id,
		input entry_count, input overflow, output ready);
endinterface

/* rtl/tspq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspq_cell
// One slot of the sorted chain: insert from the left, compact from the right.
// ----------------------------------------------------------------------------
module tspq_cell (
	input  logic                clk,
	input  tspq_pkg::cell_ctl_t ctl,
	input  logic                in_use,
	input  tspq_pkg::slot_t     left_slot,
	input  logic                left_gt,
	input  tspq_pkg::slot_t     right_slot,
	input  logic                left_hit,
	output tspq_pkg::slot_t     slot,
	output logic                gt,
	output logic                hit
);

	tspq_pkg::slot_t slot_q;
	logic            after;

	assign after = (slot_q.time_v > ctl.key.time_v) ||
		((slot_q.time_v == ctl.key.time_v) && (slot_q.id > ctl.key.id));
	assign gt    = !in_use || after;
	assign hit   = left_hit || (in_use && (slot_q.id == ctl.key.id));
	assign slot  = slot_q;

	always_ff @(posedge clk) begin
		if (ctl.push && gt) begin
			slot_q <= left_gt ? left_slot : ctl.key;
		end else if (ctl.shift && hit) begin
			slot_q <= right_slot;
		end
	end

endmodule

/* rtl/timestamp_priority_queue_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_priority_queue_unit
// Request queue sorted by time, then id, held in a chain of slot cells.
// ----------------------------------------------------------------------------
// For a push, a clear or an unused command the queue acts at the accept edge
// of the request word (a push inserts into the chain, a clear empties it) and
// the next cycle loads the response register. For a remove the chain shifts
// left by one cell past the first entry with the given id, once per matching
// entry, and the response register loads once no match is left. The queue
// takes one request at a time and needs no clearing pass after reset.
module timestamp_priority_queue_unit (
	input logic       clk,
	input logic       arst_n,
	tspq_req_if.sink  req,
	tspq_rsp_if.source rsp
);

	tspq_pkg::state_t                 state_q;
	logic [tspq_pkg::CNT_W-1:0]       count_q;
	logic [tspq_pkg::CMD_W-1:0]       cmd_q;
	tspq_pkg::slot_t                  key_q;
	logic                             ovf_q;
	logic                             rsp_valid_q;
	logic                             head_valid_q;
	tspq_pkg::slot_t                  head_q;
	logic [tspq_pkg::CNT_W-1:0]       rsp_count_q;
	logic                             rsp_ovf_q;

	tspq_pkg::cell_ctl_t              ctl;
	tspq_pkg::slot_t                  req_key;
	tspq_pkg::slot_t                  slot_w [tspq_pkg::DEPTH];
	logic [tspq_pkg::DEPTH-1:0]       gt_w;
	logic [tspq_pkg::DEPTH-1:0]       hit_w;
	logic [tspq_pkg::DEPTH-1:0]       in_use_w;
	logic                             accept;
	logic                             full;
	logic                             any_hit;

	assign req.ready = (state_q == tspq_pkg::ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == tspq_pkg::CNT_W'(tspq_pkg::DEPTH));
	assign any_hit   = hit_w[tspq_pkg::DEPTH-1];

	assign req_key.time_v = req.entry_time;
	assign req_key.id     = req.entry_id;

	assign ctl.push  = accept && (req.cmd == tspq_pkg::CMD_PUSH) && !full;
	assign ctl.shift = (state_q == tspq_pkg::ST_WORK) && (cmd_q == tspq_pkg::CMD_REMOVE)
		&& any_hit;
	assign ctl.key   = (state_q == tspq_pkg::ST_IDLE) ? req_key : key_q;

	for (genvar i = 0; i < tspq_pkg::DEPTH; i++) begin : g_cell
		assign in_use_w[i] = tspq_pkg::CNT_W'(i) < count_q;

		if (i == 0) begin : g_first
			tspq_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.in_use     (in_use_w[i]),
				.left_slot  ('0),
				.left_gt    (1'b0),
				.right_slot (slot_w[i+1]),
				.left_hit   (1'b0),
				.slot       (slot_w[i]),
				.gt         (gt_w[i]),
				.hit        (hit_w[i])
			);
		end else if (i == tspq_pkg::DEPTH - 1) begin : g_last
			tspq_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.in_use     (in_use_w[i]),
				.left_slot  (slot_w[i-1]),
				.left_gt    (gt_w[i-1]),
				.right_slot ('0),
				.left_hit   (hit_w[i-1]),
				.slot       (slot_w[i]),
				.gt         (gt_w[i]),
				.hit        (hit_w[i])
			);
		end else begin : g_mid
			tspq_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.in_use     (in_use_w[i]),
				.left_slot  (slot_w[i-1]),
				.left_gt    (gt_w[i-1]),
				.right_slot (slot_w[i+1]),
				.left_hit   (hit_w[i-1]),
				.slot       (slot_w[i]),
				.gt         (gt_w[i]),
				.hit        (hit_w[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tspq_pkg::ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			cmd_q       <= tspq_pkg::CMD_PUSH;
			ovf_q       <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				tspq_pkg::ST_IDLE: begin
					if (accept) begin
						cmd_q   <= req.cmd;
						ovf_q   <= (req.cmd == tspq_pkg::CMD_PUSH) && full;
						state_q <= tspq_pkg::ST_WORK;
						if (ctl.push) begin
							count_q <= count_q + tspq_pkg::CNT_W'(1);
						end else if (req.cmd == tspq_pkg::CMD_CLEAR) begin
							count_q <= '0;
						end
					end
				end
				tspq_pkg::ST_WORK: begin
					if (ctl.shift) begin
						count_q <= count_q - tspq_pkg::CNT_W'(1);
					end else begin
						rsp_valid_q <= 1'b1;
						state_q     <= tspq_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tspq_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= req_key;
		end
		if ((state_q == tspq_pkg::ST_WORK) && !ctl.shift) begin
			head_valid_q <= (count_q != '0);
			head_q       <= (count_q != '0) ? slot_w[0] : '0;
			rsp_count_q  <= count_q;
			rsp_ovf_q    <= ovf_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.head_valid  = head_valid_q;
	assign rsp.head_time   = head_q.time_v;
	assign rsp.head_id     = head_q.id;
	assign rsp.entry_count = rsp_count_q;
	assign rsp.overflow    = rsp_ovf_q;

endmodule

/* rtl/tspq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspq_checker
// Port-level checks of the timestamp priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tspq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic                          head_valid,
	input logic [tspq_pkg::TIME_W-1:0]   head_time,
	input logic [tspq_pkg::ID_BITS-1:0]  head_id,
	input logic [tspq_pkg::CNT_W-1:0]    entry_count,
	input logic                          overflow
);

	`TSPQ_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(entry_count) && $stable(head_time))
	`TSPQ_ASSERT(a_empty_head, rsp_valid, (head_valid == (entry_count != '0)) && (head_valid || ((head_time == '0) && (head_id == '0))))
	`TSPQ_ASSERT(a_count_max, rsp_valid, entry_count <= tspq_pkg::CNT_W'(tspq_pkg::DEPTH))
	`TSPQ_ASSERT(a_ovf_full, rsp_valid && overflow, entry_count == tspq_pkg::CNT_W'(tspq_pkg::DEPTH))
	`TSPQ_ASSERT_NXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

endmodule

bind timestamp_priority_queue_unit tspq_checker u_tspq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.head_valid  (rsp.head_valid),
	.head_time   (rsp.head_time),
	.head_id     (rsp.head_id),
	.entry_count (rsp.entry_count),
	.overflow    (rsp.overflow)
);
